// ----- hdl/ffa_pkg.sv -----
// ----------------------------------------------------------------------------
// First-fit heap allocator package
// Field widths, operation and status codes, and the control bundle types
// shared by the channels, the controller and the datapath.
// ----------------------------------------------------------------------------
package ffa_pkg;

  localparam int ADDR_W = 32;
  localparam int SIZE_W = 24;
  localparam int STAT_W = 3;

  localparam logic [ADDR_W-1:0] HEAP_LIMIT_RST = 32'd1048576;

  // Operation codes on the func field.
  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    ST_OK         = 3'd0,
    ST_ZERO       = 3'd1,
    ST_HEAP_FULL  = 3'd2,
    ST_TABLE_FULL = 3'd3,
    ST_UNKNOWN    = 3'd4
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture the accepted transaction and restart the walk
    logic walk;    // step the table walk
    logic commit;  // apply the update and load the result register
  } ffa_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic walk_done;
  } ffa_sts_t;

endpackage

// ----- hdl/ffa_in_if.sv -----
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one allocate or free request.
// ----------------------------------------------------------------------------
interface ffa_in_if import ffa_pkg::*; ();

  logic              valid;
  logic              ready;
  logic              func;
  logic [SIZE_W-1:0] request_size;
  logic [ADDR_W-1:0] release_address;

  modport source (output valid, output func, output request_size,
                  output release_address, input ready);
  modport sink   (input valid, input func, input request_size,
                  input release_address, output ready);

endinterface

// ----- hdl/ffa_out_if.sv -----
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one allocator result.
// ----------------------------------------------------------------------------
interface ffa_out_if import ffa_pkg::*; ();

  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] payload_address;
  logic [STAT_W-1:0] status;

  modport source (output valid, output payload_address, output status, input ready);
  modport sink   (input valid, input payload_address, input status, output ready);

endinterface

// ----- hdl/ffa_cfg_if.sv -----
// ----------------------------------------------------------------------------
// Configuration channel
// Valid/ready write channel for the heap limit register.
// ----------------------------------------------------------------------------
interface ffa_cfg_if import ffa_pkg::*; ();

  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

// ----- hdl/first_fit_heap_allocator.sv -----
// ----------------------------------------------------------------------------
// First-fit heap allocator
// Allocate/free engine over an address-ordered block table with a heap break.
// ----------------------------------------------------------------------------
// The request channel (in_chan) carries func, request_size and
// release_address; a transaction is taken when valid and ready are both high.
// The result channel (out_chan) returns payload_address and status, one
// result per request, in request order. The configuration channel (cfg_chan)
// writes the heap limit and is always ready; it should only be written while
// no request is in flight.
// A request walks the block table one entry per cycle through the single
// read port of the table memory, stopping at the first hit or after the
// last entry in use. The result is registered once the walk ends and the
// output register is free; a zero-size allocate or a null free skips the walk.
// A new request is taken only after the result of the previous one is
// registered, so one request is handled at a time.
// The result sits in an output register: a new request may be accepted while
// the receiver stalls, but its own result is held back until the previous one
// has been taken.
// Reset (synchronous, active low) empties the table, sets the break to zero
// and the heap limit to 1 MiB. Table contents are not cleared, since only
// entries below the count are ever read.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator import ffa_pkg::*; #(
  parameter int MAX_BLOCKS   = 64,
  parameter int HEADER_BYTES = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  ffa_in_if.sink    in_chan,
  ffa_out_if.source out_chan,
  ffa_cfg_if.sink   cfg_chan
);

  ffa_cmd_t cmd;
  ffa_sts_t sts;

  // Configuration writes are taken at any time.
  assign cfg_chan.ready = 1'b1;

  // The controller decides when a transaction is taken, walked and committed.
  ffa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath holds the table, the break and the result register.
  ffa_datapath #(
    .MAX_BLOCKS   (MAX_BLOCKS),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_datapath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_func             (in_chan.func),
    .in_request_size     (in_chan.request_size),
    .in_release_address  (in_chan.release_address),
    .cfg_we              (cfg_chan.valid),
    .cfg_data            (cfg_chan.data),
    .out_payload_address (out_chan.payload_address),
    .out_status          (out_chan.status)
  );

endmodule

// ----- hdl/ffa_ctrl.sv -----
// ----------------------------------------------------------------------------
// Allocator controller
// Sequences accept, table walk and commit, and owns the result valid flag.
// ----------------------------------------------------------------------------
module ffa_ctrl import ffa_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  ffa_sts_t sts,
  output ffa_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_ready;

  assign in_ready   = (state_r == S_IDLE);
  assign cmd.load   = in_valid && in_ready;
  assign cmd.walk   = (state_r == S_WALK);
  assign cmd.commit = (state_r == S_FINISH) && slot_free;
  assign out_valid  = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (cmd.load) state_nxt = S_WALK;
      end
      S_WALK: begin
        if (sts.walk_done) state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (slot_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase

    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // An accepted transaction always starts a walk.
  a_accept_walks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_WALK))
    else $error("accepted transaction did not start a walk");

  // A commit always presents a result on the next cycle.
  a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid_r)
    else $error("commit did not produce a result");

  // A finished walk waits while the previous result is still held.
  a_finish_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FINISH && out_valid_r && !out_ready) |=> (state_r == S_FINISH))
    else $error("result overwritten while stalled");

endmodule

// ----- hdl/ffa_datapath.sv -----
// ----------------------------------------------------------------------------
// Allocator datapath
// Block table memory, break and count registers, the walk pipeline and the
// allocate/free update logic.
// ----------------------------------------------------------------------------
module ffa_datapath import ffa_pkg::*; #(
  parameter int MAX_BLOCKS   = 64,
  parameter int HEADER_BYTES = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  ffa_cmd_t          cmd,
  output ffa_sts_t          sts,
  input  logic              in_func,
  input  logic [SIZE_W-1:0] in_request_size,
  input  logic [ADDR_W-1:0] in_release_address,
  input  logic              cfg_we,
  input  logic [ADDR_W-1:0] cfg_data,
  output logic [ADDR_W-1:0] out_payload_address,
  output logic [STAT_W-1:0] out_status
);

  localparam int IDX_W = $clog2(MAX_BLOCKS);
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam logic [CNT_W-1:0]  MAX_CNT = CNT_W'(MAX_BLOCKS);
  localparam logic [ADDR_W-1:0] HDR32   = ADDR_W'(HEADER_BYTES);
  localparam logic [ADDR_W:0]   HDR33   = (ADDR_W+1)'(HEADER_BYTES);
  localparam logic [ADDR_W+1:0] HDR34   = (ADDR_W+2)'(HEADER_BYTES);

  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [SIZE_W-1:0] size;
    logic              free;
  } entry_t;

  entry_t mem [MAX_BLOCKS];

  // Control state.
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [ADDR_W-1:0] break_r, break_nxt;
  logic [ADDR_W-1:0] limit_r;
  logic [CNT_W-1:0]  rd_idx_r;
  logic              cmp_vld_r;
  logic              hit_r;

  // Payload state.
  logic              func_r;
  logic [SIZE_W-1:0] size_r;
  logic [ADDR_W-1:0] addr_r;
  entry_t            rd_data_r;
  logic [IDX_W-1:0]  cmp_idx_r;
  logic [IDX_W-1:0]  hit_idx_r;
  entry_t            hit_entry_r;
  logic [ADDR_W-1:0] pay_r, pay_nxt;
  status_t           status_r, status_nxt;

  logic              trivial;
  logic              issue;
  logic              match;
  logic              take_hit;
  logic [ADDR_W+1:0] new_break;
  logic              heap_full;
  logic              table_full;
  logic              last_hit;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  entry_t            wr_data;

  // Requests that need no table access.
  assign trivial = (func_r == FUNC_ALLOC) ? (size_r == '0) : (addr_r == '0);

  assign issue = !trivial && !hit_r && (rd_idx_r != count_r);

  // First-fit test for allocate, payload offset match for free.
  always_comb begin
    if (func_r == FUNC_ALLOC) begin
      match = rd_data_r.free && (rd_data_r.size >= size_r);
    end else begin
      match = ({1'b0, rd_data_r.start} + HDR33) == {1'b0, addr_r};
    end
  end

  assign take_hit = cmd.walk && cmp_vld_r && !hit_r && match;

  assign sts.walk_done = trivial || hit_r || ((rd_idx_r == count_r) && !cmp_vld_r);

  assign new_break  = {2'b00, break_r} + HDR34 + (ADDR_W+2)'(size_r);
  assign heap_full  = new_break > {2'b00, limit_r};
  assign table_full = (count_r == MAX_CNT);
  assign last_hit   = (({1'b0, addr_r} + (ADDR_W+1)'(hit_entry_r.size)) == {1'b0, break_r})
                   && ((CNT_W'(hit_idx_r) + CNT_W'(1)) == count_r);

  always_comb begin
    wr_en      = 1'b0;
    wr_addr    = hit_idx_r;
    wr_data    = hit_entry_r;
    count_nxt  = count_r;
    break_nxt  = break_r;
    pay_nxt    = '0;
    status_nxt = ST_OK;
    if (func_r == FUNC_ALLOC) begin
      if (size_r == '0) begin
        status_nxt = ST_ZERO;
      end else if (hit_r) begin
        wr_en        = 1'b1;
        wr_data.free = 1'b0;
        pay_nxt      = hit_entry_r.start + HDR32;
      end else if (heap_full) begin
        status_nxt = ST_HEAP_FULL;
      end else if (table_full) begin
        status_nxt = ST_TABLE_FULL;
      end else begin
        wr_en         = 1'b1;
        wr_addr       = count_r[IDX_W-1:0];
        wr_data.start = break_r;
        wr_data.size  = size_r;
        wr_data.free  = 1'b0;
        count_nxt     = count_r + CNT_W'(1);
        break_nxt     = new_break[ADDR_W-1:0];
        pay_nxt       = break_r + HDR32;
      end
    end else begin
      if (addr_r == '0) begin
        status_nxt = ST_OK;
      end else if (hit_r) begin
        if (last_hit) begin
          count_nxt = count_r - CNT_W'(1);
          break_nxt = hit_entry_r.start;
        end else begin
          wr_en        = 1'b1;
          wr_data.free = 1'b1;
        end
      end else begin
        status_nxt = ST_UNKNOWN;
      end
    end
    if (!cmd.commit) wr_en = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      break_r   <= '0;
      limit_r   <= HEAP_LIMIT_RST;
      rd_idx_r  <= '0;
      cmp_vld_r <= 1'b0;
      hit_r     <= 1'b0;
    end else begin
      if (cfg_we) limit_r <= cfg_data;
      if (cmd.load) begin
        rd_idx_r  <= '0;
        cmp_vld_r <= 1'b0;
        hit_r     <= 1'b0;
      end else if (cmd.walk) begin
        rd_idx_r  <= rd_idx_r + CNT_W'(issue);
        cmp_vld_r <= issue;
        if (take_hit) hit_r <= 1'b1;
      end else if (cmd.commit) begin
        cmp_vld_r <= 1'b0;
        hit_r     <= 1'b0;
        count_r   <= count_nxt;
        break_r   <= break_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data_r <= mem[rd_idx_r[IDX_W-1:0]];
    cmp_idx_r <= rd_idx_r[IDX_W-1:0];
    if (cmd.load) begin
      func_r <= in_func;
      size_r <= in_request_size;
      addr_r <= in_release_address;
    end
    if (take_hit) begin
      hit_idx_r   <= cmp_idx_r;
      hit_entry_r <= rd_data_r;
    end
    if (cmd.commit) begin
      pay_r    <= pay_nxt;
      status_r <= status_nxt;
    end
  end

  assign out_payload_address = pay_r;
  assign out_status          = status_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= MAX_CNT)
    else $error("entry count beyond table capacity");

  a_hit_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    hit_r |-> (CNT_W'(hit_idx_r) < count_r))
    else $error("walk hit outside the used table");

  a_cmp_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    cmp_vld_r |-> (CNT_W'(cmp_idx_r) < count_r))
    else $error("compare stage holds an unused entry");

endmodule

// ----- bench/first_fit_heap_allocator_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// First-fit heap allocator testbench
// Sends allocate and free requests with random idle gaps on both channels,
// predicts each result from a private copy of the block table, break and
// heap limit, and compares every result transaction with its prediction.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_test import ffa_pkg::*; ();

  localparam int MAX_BLOCKS   = 64;
  localparam int HEADER_BYTES = 16;
  // Margin for a request that walks every table entry, with its overhead.
  localparam int WALK_CYCLES  = MAX_BLOCKS + 8;
  // Length of the long receiver hold-off that backs the block up.
  localparam int HOLD_CYCLES  = 400;
  localparam int CYCLE_LIMIT  = 1000000;

  // How a free request picks its address. Free requests that target a live
  // block resolve their address only when they are put on the bus, because
  // only then is the table state known.
  typedef enum logic [1:0] {
    AIM_NONE,  // use the address as given
    AIM_LIVE,  // payload offset of some block in the table
    AIM_LAST,  // payload offset of the block next to the break
    AIM_NEAR   // a few bytes past a live payload offset
  } free_aim_t;

  typedef struct {
    logic              func;
    logic [SIZE_W-1:0] size;
    logic [ADDR_W-1:0] addr;
    free_aim_t         aim;
    int unsigned       pick;
  } heap_req_t;

  typedef struct {
    logic [ADDR_W-1:0] payload_address;
    status_t           status;
  } heap_result_t;

  logic clk = 1'b0;
  logic rst_n;

  ffa_in_if  in_chan ();
  ffa_out_if out_chan ();
  ffa_cfg_if cfg_chan ();

  first_fit_heap_allocator #(
    .MAX_BLOCKS   (MAX_BLOCKS),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  always #6 clk = ~clk;

  // --------------------------------------------------------------------------
  // Shadow of the allocator state, advanced once per accepted request.
  // --------------------------------------------------------------------------
  logic [ADDR_W-1:0] blk_start [MAX_BLOCKS];
  logic [SIZE_W-1:0] blk_size  [MAX_BLOCKS];
  logic              blk_free  [MAX_BLOCKS];
  int                blk_count = 0;
  logic [ADDR_W-1:0] heap_break = '0;
  logic [ADDR_W-1:0] heap_limit_model;

  heap_req_t    pending_reqs [$];
  heap_result_t expected_results [$];
  heap_req_t    cur_req;
  heap_result_t got_result;

  bit          req_live;
  int          send_gap;
  int          stall_left;
  int          hold_left;
  int unsigned hold_asked;
  int unsigned hold_given = 0;
  logic        calm;
  int          mismatches = 0;
  int          cycles_run = 0;

  // First fit over the table; failing that, grow the heap at the break.
  // The heap limit is tested before the table capacity, so heap full wins
  // when both would fail.
  function automatic heap_result_t model_alloc(logic [SIZE_W-1:0] size);
    heap_result_t      res;
    longint unsigned   grown;
    bit                found;
    res.payload_address = '0;
    res.status          = ST_OK;
    found               = 1'b0;
    if (size == '0) begin
      res.status = ST_ZERO;
      return res;
    end
    for (int i = 0; i < blk_count; i++) begin
      if (!found && blk_free[i] && blk_size[i] >= size) begin
        blk_free[i]         = 1'b0;
        res.payload_address = blk_start[i] + ADDR_W'(HEADER_BYTES);
        found               = 1'b1;
      end
    end
    if (found) return res;
    grown = 64'(heap_break) + 64'(HEADER_BYTES) + 64'(size);
    if (grown > 64'(heap_limit_model)) begin
      res.status = ST_HEAP_FULL;
      return res;
    end
    if (blk_count >= MAX_BLOCKS) begin
      res.status = ST_TABLE_FULL;
      return res;
    end
    blk_start[blk_count] = heap_break;
    blk_size[blk_count]  = size;
    blk_free[blk_count]  = 1'b0;
    blk_count++;
    res.payload_address = heap_break + ADDR_W'(HEADER_BYTES);
    heap_break          = ADDR_W'(grown);
    return res;
  endfunction

  // A block that ends at the break and is last in the table gives its space
  // back; any other known block is only marked free, even if it already is.
  function automatic status_t model_free(logic [ADDR_W-1:0] addr);
    int          hit;
    logic [32:0] stop;
    hit = -1;
    if (addr == '0) return ST_OK;
    for (int i = 0; i < blk_count; i++) begin
      if (hit < 0 && {1'b0, blk_start[i]} + 33'(HEADER_BYTES) == {1'b0, addr}) hit = i;
    end
    if (hit < 0) return ST_UNKNOWN;
    stop = {1'b0, addr} + 33'(blk_size[hit]);
    if (stop == {1'b0, heap_break} && hit == blk_count - 1) begin
      blk_count--;
      heap_break = blk_start[hit];
    end else begin
      blk_free[hit] = 1'b1;
    end
    return ST_OK;
  endfunction

  function automatic void predict_request(heap_req_t r);
    heap_result_t res;
    res.payload_address = '0;
    res.status          = ST_OK;
    if (r.func == FUNC_ALLOC) res = model_alloc(r.size);
    else res.status = model_free(r.addr);
    expected_results.push_back(res);
  endfunction

  function automatic logic [ADDR_W-1:0] free_target(heap_req_t r);
    if (blk_count == 0) return r.addr;
    case (r.aim)
      AIM_LIVE: return blk_start[r.pick % blk_count] + ADDR_W'(HEADER_BYTES);
      AIM_LAST: return blk_start[blk_count - 1] + ADDR_W'(HEADER_BYTES);
      AIM_NEAR: return blk_start[r.pick % blk_count] + ADDR_W'(HEADER_BYTES)
                       + ADDR_W'(r.pick % 15 + 1);
      default:  return r.addr;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus builders.
  // --------------------------------------------------------------------------
  function automatic void queue_alloc(logic [SIZE_W-1:0] size);
    heap_req_t r;
    r.func = FUNC_ALLOC;
    r.size = size;
    r.addr = ADDR_W'($urandom());
    r.aim  = AIM_NONE;
    r.pick = $urandom();
    pending_reqs.push_back(r);
  endfunction

  function automatic void queue_free(free_aim_t aim, logic [ADDR_W-1:0] addr);
    heap_req_t r;
    r.func = FUNC_FREE;
    r.size = SIZE_W'($urandom());
    r.addr = addr;
    r.aim  = aim;
    r.pick = $urandom();
    pending_reqs.push_back(r);
  endfunction

  // Mostly small blocks, so the table fills before the heap does; a few
  // large and full-width sizes reach the heap limit.
  function automatic logic [SIZE_W-1:0] random_size();
    int s;
    s = $urandom_range(0, 99);
    if (s < 60) return SIZE_W'($urandom_range(1, 64));
    if (s < 88) return SIZE_W'($urandom_range(1, 4096));
    if (s < 98) return SIZE_W'($urandom());
    return '1;
  endfunction

  // Well-formed traffic (allocations and frees of live blocks) with about
  // one request in twelve being noise: zero sizes, null frees, wild and
  // near-miss addresses. alloc_pct must stay below 85.
  task automatic queue_random(int n, int alloc_pct);
    int r;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < alloc_pct) queue_alloc(random_size());
      else if (r < 92) queue_free(($urandom_range(0, 2) == 0) ? AIM_LAST : AIM_LIVE, '0);
      else if (r < 94) queue_alloc('0);
      else if (r < 95) queue_free(AIM_NONE, '0);
      else if (r < 97) queue_free(AIM_NONE, ADDR_W'($urandom()));
      else if (r < 99) queue_free(AIM_NEAR, '0);
      else queue_alloc('1);
    end
  endtask

  // The block is idle once every queued request has been taken and every
  // result has come back; the extra cycles cover a walk still in progress.
  task automatic wait_idle();
    while (pending_reqs.size() != 0 || req_live || expected_results.size() != 0)
      @(posedge clk);
    repeat (WALK_CYCLES) @(posedge clk);
  endtask

  task automatic write_heap_limit(logic [ADDR_W-1:0] value);
    @(posedge clk);
    cfg_chan.valid <= 1'b1;
    cfg_chan.data  <= value;
    do @(posedge clk); while (!cfg_chan.ready);
    heap_limit_model = value;
    cfg_chan.valid <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Request driver. A transaction completes at an edge where valid and ready
  // are both high; the request is then fed to the predictor, and the next
  // one is taken from the queue after an optional idle burst.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      req_live = 1'b0;
      send_gap = 0;
      in_chan.valid           <= 1'b0;
      in_chan.func            <= FUNC_ALLOC;
      in_chan.request_size    <= '0;
      in_chan.release_address <= '0;
    end else begin
      if (in_chan.valid && in_chan.ready) begin
        predict_request(cur_req);
        req_live = 1'b0;
        if (!calm && $urandom_range(0, 4) == 0) send_gap = $urandom_range(1, 17);
      end
      if (!req_live) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_reqs.size() > 0) begin
          cur_req = pending_reqs.pop_front();
          if (cur_req.func == FUNC_FREE) cur_req.addr = free_target(cur_req);
          req_live = 1'b1;
          in_chan.func            <= cur_req.func;
          in_chan.request_size    <= cur_req.size;
          in_chan.release_address <= cur_req.addr;
        end
      end
      in_chan.valid <= req_live;
    end
  end

  // --------------------------------------------------------------------------
  // Result receiver. Ready drops in random bursts; on request it drops for a
  // long hold-off so that the output register fills and the block stops
  // taking requests while the driver keeps offering them.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      stall_left = 0;
      hold_left  = 0;
      out_chan.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_chan.ready <= 1'b0;
    end else if (hold_asked != hold_given) begin
      hold_given++;
      hold_left = HOLD_CYCLES;
      out_chan.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_chan.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 16);
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= 1'b1;
    end
  end

  // Every result transaction is checked against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result with none expected, payload_address %h status %0d",
                 $time, out_chan.payload_address, out_chan.status);
        mismatches++;
      end else begin
        got_result = expected_results.pop_front();
        if (out_chan.payload_address !== got_result.payload_address) begin
          $display("%0t: payload_address mismatch, expected %h, actual %h",
                   $time, got_result.payload_address, out_chan.payload_address);
          mismatches++;
        end
        if (out_chan.status !== got_result.status) begin
          $display("%0t: status mismatch, expected %0d, actual %0d",
                   $time, got_result.status, out_chan.status);
          mismatches++;
        end
      end
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk) begin
    cycles_run++;
    if (cycles_run >= CYCLE_LIMIT) begin
      $display("%0t: cycle limit reached", $time);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence.
  // --------------------------------------------------------------------------
  initial begin
    cfg_chan.valid          = 1'b0;
    cfg_chan.data           = '0;
    calm                    = 1'b0;
    hold_asked              = 0;
    heap_limit_model        = HEAP_LIMIT_RST;
    rst_n                   = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed requests under the reset heap limit of 1 MiB.
    queue_alloc('0);                          // zero size gives null
    queue_free(AIM_NONE, '0);                 // null free is a no-op
    queue_free(AIM_NONE, '1);                 // unknown address
    queue_alloc(SIZE_W'(1));                  // first block at offset 0
    queue_alloc('1);                          // largest size overflows the heap
    queue_alloc(SIZE_W'(100));
    queue_alloc(SIZE_W'(8));
    queue_free(AIM_NONE, ADDR_W'(16));        // inner block is only marked free
    queue_free(AIM_NONE, ADDR_W'(16));        // double free stays free
    queue_alloc(SIZE_W'(1));                  // reuses the freed first block
    queue_free(AIM_NONE, ADDR_W'(49));
    queue_alloc(SIZE_W'(200));                // no free block to reuse, appends
    queue_free(AIM_LAST, '0);                 // break retreats
    queue_free(AIM_LAST, '0);
    queue_free(AIM_LAST, '0);                 // next block at the break goes too
    queue_free(AIM_NEAR, '0);                 // near miss is unknown
    queue_alloc(SIZE_W'(1048576 - 17 - 16));  // exactly reaches the limit
    queue_free(AIM_LAST, '0);
    queue_alloc(SIZE_W'(1048576 - 17 - 15));  // one byte over the limit
    queue_free(AIM_NONE, ADDR_W'(16));
    wait_idle();

    // Unlimited heap: allocation-heavy traffic runs the table full, with a
    // long receiver hold-off while the requests pour in.
    write_heap_limit('1);
    queue_random(320, 80);
    hold_asked <= hold_asked + 1;
    wait_idle();

    // Zero limit, below the current break: appends fail, frees still work.
    write_heap_limit('0);
    queue_random(40, 50);
    wait_idle();

    // Small heap, where heap full is common.
    write_heap_limit(ADDR_W'(4096));
    queue_random(300, 55);
    wait_idle();

    write_heap_limit(HEAP_LIMIT_RST);
    queue_random(370, 45);
    hold_asked <= hold_asked + 1;
    wait_idle();

    // Last part at full rate, with no idling on either side.
    write_heap_limit(ADDR_W'(32'h0002_0000));
    calm <= 1'b1;
    queue_random(300, 60);
    wait_idle();

    if (mismatches == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
